// ===== hw/rtl/stdt_pkg.sv =====
// ----------------------------------------------------------------------------
// stdt_pkg
// Shared constants, types and helper functions for the signed integer to
// decimal text converter.
// ----------------------------------------------------------------------------
package stdt_pkg;

	localparam int ValueW      = 64;
	localparam int CharW       = 8;
	localparam int NumDigits   = 19;
	localparam int BcdW        = NumDigits * 4;
	localparam int BitsPerStep = 2;
	localparam int NumSteps    = ValueW / BitsPerStep;
	localparam int StepCntW    = $clog2(NumSteps);
	localparam int DigitIdxW   = $clog2(NumDigits);
	localparam int QueueDepth  = 2;
	localparam int QueuePtrW   = $clog2(QueueDepth);
	localparam int QueueCntW   = $clog2(QueueDepth + 1);

	localparam logic [CharW-1:0] CharMinus = 8'd45;
	localparam logic [CharW-1:0] CharZero  = 8'd48;
	localparam logic [CharW-1:0] CharOne   = 8'd49;
	localparam logic [CharW-1:0] CharNine  = 8'd57;

	typedef struct packed {
		logic              neg;
		logic [ValueW-1:0] mag;
	} stdt_entry_t;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_RUN,
		CV_HOLD
	} stdt_cv_state_t;

	// One shift-and-add-3 step: correct every BCD digit, then shift in one bit.
	function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd,
		input logic bit_in);
		logic [BcdW-1:0] adj;
		adj = bcd;
		for (int d = 0; d < NumDigits; d++) begin
			if (adj[d*4 +: 4] >= 4'd5) begin
				adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
			end
		end
		return {adj[BcdW-2:0], bit_in};
	endfunction

	// Index of the most significant nonzero digit, zero when all digits are zero.
	function automatic logic [DigitIdxW-1:0] first_digit(input logic [BcdW-1:0] bcd);
		logic [DigitIdxW-1:0] idx;
		idx = '0;
		for (int d = 0; d < NumDigits; d++) begin
			if (bcd[d*4 +: 4] != 4'd0) begin
				idx = DigitIdxW'(d);
			end
		end
		return idx;
	endfunction

endpackage

// ===== hw/rtl/stdt_front.sv =====
// ----------------------------------------------------------------------------
// stdt_front
// Accepts input values, splits each into a sign flag and an unsigned
// magnitude, and writes the result into the work queue.
// ----------------------------------------------------------------------------
module stdt_front import stdt_pkg::*; (
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic signed [ValueW-1:0] value,
	input  logic                     queue_full,
	output logic                     wr_valid,
	output stdt_entry_t              wr_entry
);

	logic [ValueW-1:0] raw;

	assign raw            = ValueW'(value);
	assign item_stall     = queue_full;
	assign wr_valid       = item_valid && !queue_full;
	assign wr_entry.neg   = raw[ValueW-1];
	assign wr_entry.mag   = raw[ValueW-1] ? (ValueW'(0) - raw) : raw;

endmodule

// ===== hw/rtl/stdt_queue.sv =====
// ----------------------------------------------------------------------------
// stdt_queue
// Short first-in first-out queue of classified values between the front
// and the conversion engine.
// ----------------------------------------------------------------------------
module stdt_queue import stdt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_valid,
	input  stdt_entry_t wr_entry,
	output logic        full,
	input  logic        rd_pop,
	output logic        rd_valid,
	output stdt_entry_t rd_entry
);

	stdt_entry_t          slot_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full     = (count_q == QueueCntW'(QueueDepth));
	assign rd_valid = (count_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && !full;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QueueCntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QueueCntW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/stdt_back.sv =====
// ----------------------------------------------------------------------------
// stdt_back
// Converts a magnitude to BCD by shift-and-add-3, two bits per cycle, then
// hands the digits to an output stage that sends the sign and the digits
// one beat at a time, most significant first, without leading zeros.
// ----------------------------------------------------------------------------
module stdt_back import stdt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_valid,
	input  stdt_entry_t      rd_entry,
	output logic             rd_pop,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [CharW-1:0] character,
	output logic             is_last
);

	stdt_cv_state_t       cv_state_q;
	stdt_cv_state_t       cv_next;
	logic [StepCntW-1:0]  cnt_q;
	logic [ValueW-1:0]    shift_q;
	logic [BcdW-1:0]      bcd_q;
	logic [BcdW-1:0]      bcd_next;
	logic                 neg_q;
	logic                 load;
	logic                 handoff;

	logic                 em_valid_q;
	logic                 em_sign_q;
	logic [DigitIdxW-1:0] em_idx_q;
	logic [BcdW-1:0]      em_bcd_q;
	logic                 em_free;
	logic                 out_accept;

	assign out_accept = em_valid_q && !result_stall;
	assign em_free    = !em_valid_q || (out_accept && is_last);

	always_comb begin
		cv_next = cv_state_q;
		case (cv_state_q)
			CV_IDLE: begin
				if (rd_valid) begin
					cv_next = CV_RUN;
				end
			end
			CV_RUN: begin
				if (cnt_q == StepCntW'(NumSteps - 1)) begin
					cv_next = CV_HOLD;
				end
			end
			CV_HOLD: begin
				if (em_free) begin
					cv_next = rd_valid ? CV_RUN : CV_IDLE;
				end
			end
			default: begin
				cv_next = CV_IDLE;
			end
		endcase
	end

	always_comb begin
		load    = 1'b0;
		handoff = 1'b0;
		case (cv_state_q)
			CV_IDLE: begin
				load = rd_valid;
			end
			CV_RUN: begin
				load = 1'b0;
			end
			CV_HOLD: begin
				handoff = em_free;
				load    = em_free && rd_valid;
			end
			default: begin
				load    = 1'b0;
				handoff = 1'b0;
			end
		endcase
	end

	assign rd_pop = load;

	always_comb begin
		bcd_next = bcd_q;
		for (int b = 0; b < BitsPerStep; b++) begin
			bcd_next = dabble_step(bcd_next, shift_q[ValueW-1-b]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_state_q <= CV_IDLE;
			cnt_q      <= '0;
		end else begin
			cv_state_q <= cv_next;
			if (load) begin
				cnt_q <= '0;
			end else if (cv_state_q == CV_RUN) begin
				cnt_q <= cnt_q + StepCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= rd_entry.mag;
			bcd_q   <= '0;
			neg_q   <= rd_entry.neg;
		end else if (cv_state_q == CV_RUN) begin
			shift_q <= shift_q << BitsPerStep;
			bcd_q   <= bcd_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_sign_q  <= 1'b0;
			em_idx_q   <= '0;
		end else if (handoff) begin
			em_valid_q <= 1'b1;
			em_sign_q  <= neg_q;
			em_idx_q   <= first_digit(bcd_q);
		end else if (out_accept) begin
			if (em_sign_q) begin
				em_sign_q <= 1'b0;
			end else if (em_idx_q == '0) begin
				em_valid_q <= 1'b0;
			end else begin
				em_idx_q <= em_idx_q - DigitIdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (handoff) begin
			em_bcd_q <= bcd_q;
		end
	end

	assign result_valid = em_valid_q;
	assign character    = em_sign_q ? CharMinus
		: (CharZero + CharW'(em_bcd_q[em_idx_q*4 +: 4]));
	assign is_last      = !em_sign_q && (em_idx_q == '0);

endmodule

// ===== hw/rtl/signed_integer_to_decimal_text_top.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_decimal_text_top
// Converts signed 64-bit integers to ASCII decimal text, one character a beat.
// ----------------------------------------------------------------------------
// Input channel: item_valid, item_stall and value. A value is taken on a
// clock edge with item_valid high and item_stall low. Values go into a
// two-entry queue, so the source is stalled only while that queue is full.
// Output channel: result_valid, result_stall, character and is_last. Each
// value gives an optional '-' then its digits, most significant first, with
// no leading zeros; zero gives a single '0'. is_last marks the final digit.
// Conversion: the BCD conversion runs two bits a cycle and overlaps with the
// sending of the previous value's text. The text of one value is at most
// 20 characters long.
// When result_stall is high the current character and is_last hold; the
// conversion of the next value finishes and then waits for the output stage.
// Reset (arst_n low) empties the queue and drops any text not yet sent.
// ----------------------------------------------------------------------------
module signed_integer_to_decimal_text_top import stdt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic signed [ValueW-1:0] value,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [CharW-1:0]         character,
	output logic                     is_last
);

	logic        queue_full;
	logic        wr_valid;
	stdt_entry_t wr_entry;
	logic        rd_pop;
	logic        rd_valid;
	stdt_entry_t rd_entry;

	stdt_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.value      (value),
		.queue_full (queue_full),
		.wr_valid   (wr_valid),
		.wr_entry   (wr_entry)
	);

	stdt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_entry (wr_entry),
		.full     (queue_full),
		.rd_pop   (rd_pop),
		.rd_valid (rd_valid),
		.rd_entry (rd_entry)
	);

	stdt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_valid     (rd_valid),
		.rd_entry     (rd_entry),
		.rd_pop       (rd_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.character    (character),
		.is_last      (is_last)
	);

endmodule

// ===== hw/rtl/stdt_checker.sv =====
// ----------------------------------------------------------------------------
// stdt_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
module stdt_checker import stdt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input logic [CharW-1:0] character,
	input logic             is_last
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result_valid dropped while stalled");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (character == CharMinus)
			|| ((character >= CharZero) && (character <= CharNine)))
		else $error("character is neither a sign nor a digit");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (character == CharMinus) |-> !is_last)
		else $error("sign flagged as last beat");

	a_digit_after_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && (character == CharMinus)
		|=> result_valid && (character >= CharOne) && (character <= CharNine))
		else $error("sign not followed at once by a nonzero digit");

endmodule

bind signed_integer_to_decimal_text_top stdt_checker u_stdt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.character    (character),
	.is_last      (is_last)
);

// ===== verif/signed_integer_to_decimal_text_top_test.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_decimal_text_top_test
// Sends signed 64-bit values through the converter and checks every character
// and end flag of their decimal text. It uses directed extremes first, then
// random values of every length, with random gaps and stalls on both sides
// and one long output hold that fills the block.
// ----------------------------------------------------------------------------
module signed_integer_to_decimal_text_top_test import stdt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ClkPeriod    = 10;
	localparam int ResetCycles  = 8;
	localparam int RandomValues = 192;
	localparam int DrainCycles  = 60;
	localparam int HoldCycles   = 400;
	localparam int HoldAfter    = 250;
	localparam int CycleLimit   = 1_000_000;
	localparam int Radix        = 10;
	localparam int MaxChars     = NumDigits + 1;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             last;
	} text_char_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     item_valid   = 1'b0;
	logic                     item_stall;
	logic signed [ValueW-1:0] value        = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b1;
	logic [CharW-1:0]         character;
	logic                     is_last;

	logic [ValueW-1:0] pending_values [$];
	text_char_t        expected_text [$];

	int mismatch_count = 0;
	int results_seen   = 0;
	int cycle_count    = 0;
	int send_gap       = 0;
	int tx_calm        = 0;
	int stall_left     = 0;
	int rx_calm        = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;

	signed_integer_to_decimal_text_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.value        (value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.character    (character),
		.is_last      (is_last)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Queues the characters a value must produce, sign first, then digits from the top.
	function automatic void predict_text(input logic [ValueW-1:0] raw);
		logic [ValueW-1:0] mag;
		logic [3:0]        digits [MaxChars];
		int                ndig;
		mag  = raw[ValueW-1] ? (ValueW'(0) - raw) : raw;
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % Radix);
			mag          = mag / Radix;
			ndig++;
		end while (mag != 0 && ndig < MaxChars);
		if (raw[ValueW-1]) begin
			expected_text.push_back('{ch: CharMinus, last: 1'b0});
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			expected_text.push_back('{ch: CharZero + CharW'(digits[k]), last: (k == 0)});
		end
	endfunction

	function automatic logic [ValueW-1:0] random_value();
		logic [ValueW-1:0] v;
		logic [ValueW-1:0] scale;
		int                kind;
		int                ndig;
		kind = $urandom_range(0, 9);
		v    = {$urandom, $urandom};
		if (kind < 4) begin
			return v;
		end
		scale = ValueW'(1);
		ndig  = $urandom_range(1, NumDigits);
		for (int i = 0; i < ndig; i++) begin
			scale = scale * Radix;
		end
		if (kind < 8) begin
			v = v % scale;
		end else if (kind == 8) begin
			v = scale - 1;
		end else begin
			v = scale;
		end
		if ($urandom_range(0, 1) == 1) begin
			v = ValueW'(0) - v;
		end
		return v;
	endfunction

	// Mostly no pause or a short one, now and then a long one, and calm stretches without any.
	function automatic int pick_pause(inout int calm_left);
		int roll;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 60) begin
			return 0;
		end
		if (roll < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin : sender
		logic              next_valid;
		logic [ValueW-1:0] next_value;
		if (!arst_n) begin
			item_valid <= 1'b0;
			value      <= '0;
			send_gap   = 0;
		end else begin
			next_valid = item_valid;
			next_value = value;
			if (item_valid && !item_stall) begin
				predict_text(value);
				void'(pending_values.pop_front());
				send_gap   = pick_pause(tx_calm);
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_values.size() > 0) begin
					next_valid = 1'b1;
					next_value = pending_values[0];
				end
			end
			item_valid <= next_valid;
			value      <= next_value;
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		text_char_t want;
		logic       next_stall;
		if (!arst_n) begin
			result_stall <= 1'b1;
			stall_left   = 0;
			hold_left    = 0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected character %0d", character));
				end else begin
					want = expected_text.pop_front();
					if (character !== want.ch) begin
						report_mismatch($sformatf("character %0d, expected %0d",
							character, want.ch));
					end
					if (is_last !== want.last) begin
						report_mismatch($sformatf("is_last %0b, expected %0b on character %0d",
							is_last, want.last, want.ch));
					end
				end
			end
			if (!hold_done && results_seen >= HoldAfter) begin
				hold_done = 1'b1;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_stall = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else begin
				stall_left = pick_pause(rx_calm);
				next_stall = (stall_left > 0);
				if (next_stall) begin
					stall_left--;
				end
			end
			result_stall <= next_stall;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		pending_values = '{
			64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100,
			-64'sd100, 64'd1234567890, -64'sd987654321, 64'd1000000000000000000,
			-64'sd999999999999999999, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000
		};
		for (int n = 0; n < RandomValues; n++) begin
			pending_values.push_back(random_value());
		end
		arst_n = 1'b0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_values.size() > 0 || expected_text.size() > 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
